// ===== rtl/srp_pkg.sv =====
// Shared constants, codes and types for the skyline rectangle packer.
`timescale 1ns / 1ps
package srp_pkg;

  localparam int MAX_BIN_WIDTH = 1024;
  localparam int ADDR_W = $clog2(MAX_BIN_WIDTH);
  localparam int CNT_W = ADDR_W + 1;
  localparam int SUM_W = CNT_W + 1;
  localparam int H_W = 11;

  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_PLACE = 1'b1;

  localparam logic REG_BIN_WIDTH = 1'b0;
  localparam logic REG_BIN_HEIGHT = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FWD,
    ST_TURN,
    ST_BWD,
    ST_DRAIN,
    ST_DECIDE,
    ST_WRITE,
    ST_RESULT
  } srp_state_t;

  // Control travelling alongside one memory read, registered at the issue so it lines up with the read data.
  typedef struct packed {
    logic              start;
    logic              fwd_v;
    logic              fwd_first;
    logic              bwd_v;
    logic              bwd_blkend;
    logic              bwd_win;
    logic [ADDR_W-1:0] col;
  } srp_ctrl_t;

endpackage

// ===== rtl/srp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module srp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/srp_search.sv =====
// Window-maximum search: block prefix maxima forward, suffix maxima backward, running minimum.
`timescale 1ns / 1ps
module srp_search
  import srp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  srp_ctrl_t         ctrl,
  input  logic [H_W-1:0]    h,
  input  logic [H_W-1:0]    p,
  output logic [H_W-1:0]    prefix,
  output logic              found,
  output logic [H_W-1:0]    best,
  output logic [ADDR_W-1:0] best_x
);

  logic [H_W-1:0] prefix_q;
  logic [H_W-1:0] suffix_q;
  logic [H_W-1:0] suffix;
  logic [H_W-1:0] win_max;
  logic           take;

  always_comb begin
    prefix  = (ctrl.fwd_first || h > prefix_q) ? h : prefix_q;
    suffix  = (ctrl.bwd_blkend || h > suffix_q) ? h : suffix_q;
    win_max = (p > suffix) ? p : suffix;
    // scanning right to left, so <= keeps the leftmost window on ties
    take    = ctrl.bwd_v && ctrl.bwd_win && (!found || win_max <= best);
  end

  always_ff @(posedge clk) begin
    if (ctrl.fwd_v) begin
      prefix_q <= prefix;
    end
    if (ctrl.bwd_v) begin
      suffix_q <= suffix;
    end
    if (take) begin
      best   <= win_max;
      best_x <= ctrl.col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctrl.start) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

endmodule

// ===== rtl/skyline_rect_packer.sv =====
// Skyline rectangle packer: sequencer, skyline and prefix memories, result register.
// Place: one forward and one backward pass over the skyline memory up to the effective
//   bin width, then one write per span column (none on a miss).
// Too wide, or zero width: no pass. Clear: a zero sweep over all MAX_BIN_WIDTH columns.
// One item at a time; the next is taken while a result waits in the output register.
// Reset: a zeroing pass over all MAX_BIN_WIDTH columns with in_stall high; config writes taken.
`timescale 1ns / 1ps
module skyline_rect_packer
  import srp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [10:0]      cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             operation,
  input  logic [10:0]      rect_width,
  input  logic [10:0]      rect_height,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             placed,
  output logic [9:0]       pos_x,
  output logic [10:0]      pos_y
);

  srp_state_t state, state_next;

  logic [10:0]      bin_width;
  logic [10:0]      bin_height;
  logic [CNT_W-1:0] wide_now;

  logic [CNT_W-1:0]  col;
  logic [CNT_W-1:0]  pos;
  logic [CNT_W-1:0]  last_pos;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  wide;
  logic [CNT_W-1:0]  rw_m1;
  logic [10:0]       rw;
  logic [10:0]       rh;
  logic [H_W-1:0]    top;
  logic              report;
  logic              res_placed;
  logic [ADDR_W-1:0] res_x;
  logic [H_W-1:0]    res_y;

  logic              sky_we;
  logic [ADDR_W-1:0] sky_addr;
  logic [H_W-1:0]    sky_wdata;
  logic [H_W-1:0]    sky_rdata;
  logic              p_we;
  logic [ADDR_W-1:0] p_raddr;
  logic [H_W-1:0]    p_rdata;
  logic [H_W-1:0]    prefix;
  logic [SUM_W-1:0]  win_end;

  srp_ctrl_t ctrl_d, ctrl_q;

  logic              found;
  logic [H_W-1:0]    best;
  logic [ADDR_W-1:0] best_x;

  logic              accept;
  logic              too_wide;
  logic [H_W-1:0]    cand_y;
  logic [ADDR_W-1:0] cand_x;
  logic              fit;
  logic              out_load;

  assign wide_now = (32'(bin_width) > MAX_BIN_WIDTH) ? CNT_W'(MAX_BIN_WIDTH)
                                                     : CNT_W'(bin_width);
  assign accept   = in_valid && !in_stall;
  assign too_wide = 32'(rect_width) > 32'(wide_now);
  assign rw_m1    = CNT_W'(rw) - CNT_W'(1);
  assign win_end  = SUM_W'(col) + SUM_W'(rw);
  assign p_raddr  = ADDR_W'(win_end - SUM_W'(1));
  assign out_load = (state == ST_RESULT) && (!out_valid || !out_stall);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_width  <= 11'd1024;
      bin_height <= 11'd1024;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BIN_WIDTH:  bin_width  <= cfg_data;
        REG_BIN_HEIGHT: bin_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // candidate from the search; no window below the limit falls back to x 0, y limit
  always_comb begin
    if (rw == 11'd0) begin
      cand_y = '0;
      cand_x = '0;
    end else if (found && best < bin_height) begin
      cand_y = best;
      cand_x = best_x;
    end else begin
      cand_y = bin_height;
      cand_x = '0;
    end
    fit = ({1'b0, cand_y} + {1'b0, rh}) <= {1'b0, bin_height};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    sky_we     = 1'b0;
    sky_addr   = col[ADDR_W-1:0];
    sky_wdata  = '0;
    ctrl_d     = '0;
    ctrl_d.col = col[ADDR_W-1:0];
    case (state)
      ST_CLEAR: begin
        sky_we = 1'b1;
        if (col == CNT_W'(MAX_BIN_WIDTH - 1)) begin
          state_next = report ? ST_RESULT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (operation == OP_CLEAR) begin
            state_next = ST_CLEAR;
          end else if (too_wide) begin
            state_next = ST_RESULT;
          end else if (rect_width == 11'd0) begin
            state_next = ST_DECIDE;
          end else begin
            state_next   = ST_FWD;
            ctrl_d.start = 1'b1;
          end
        end
      end
      ST_FWD: begin
        ctrl_d.fwd_v     = 1'b1;
        ctrl_d.fwd_first = (pos == '0);
        if (col == wide - CNT_W'(1)) begin
          state_next = ST_TURN;
        end
      end
      ST_TURN: begin
        // lets the last prefix write land before the backward reads start
        state_next = ST_BWD;
      end
      ST_BWD: begin
        ctrl_d.bwd_v      = 1'b1;
        ctrl_d.bwd_blkend = (pos == rw_m1) || (col == wide - CNT_W'(1));
        ctrl_d.bwd_win    = win_end <= SUM_W'(wide);
        if (col == '0) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_next = (fit && rw != 11'd0) ? ST_WRITE : ST_RESULT;
      end
      ST_WRITE: begin
        sky_we    = 1'b1;
        sky_wdata = top;
        if (cnt == CNT_W'(1)) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // sequencer datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      col    <= '0;
      report <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          col <= col + CNT_W'(1);
        end
        ST_IDLE: begin
          if (accept) begin
            rw         <= rect_width;
            rh         <= rect_height;
            wide       <= wide_now;
            col        <= '0;
            pos        <= '0;
            report     <= 1'b1;
            res_placed <= (operation == OP_CLEAR);
            res_x      <= '0;
            res_y      <= '0;
          end
        end
        ST_FWD: begin
          col      <= col + CNT_W'(1);
          pos      <= (pos == rw_m1) ? '0 : pos + CNT_W'(1);
          last_pos <= pos;
        end
        ST_TURN: begin
          col <= wide - CNT_W'(1);
          pos <= last_pos;
        end
        ST_BWD: begin
          col <= col - CNT_W'(1);
          pos <= (pos == '0) ? rw_m1 : pos - CNT_W'(1);
        end
        ST_DECIDE: begin
          res_placed <= fit;
          res_x      <= fit ? cand_x : '0;
          res_y      <= fit ? cand_y : '0;
          top        <= cand_y + rh;
          col        <= CNT_W'(cand_x);
          cnt        <= CNT_W'(rw);
        end
        ST_WRITE: begin
          col <= col + CNT_W'(1);
          cnt <= cnt - CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_d;
    end
  end

  assign p_we = ctrl_q.fwd_v;

  srp_ram #(
    .WIDTH(H_W),
    .DEPTH(MAX_BIN_WIDTH)
  ) u_sky_ram (
    .clk  (clk),
    .we   (sky_we),
    .waddr(sky_addr),
    .wdata(sky_wdata),
    .raddr(sky_addr),
    .rdata(sky_rdata)
  );

  srp_ram #(
    .WIDTH(H_W),
    .DEPTH(MAX_BIN_WIDTH)
  ) u_pfx_ram (
    .clk  (clk),
    .we   (p_we),
    .waddr(ctrl_q.col),
    .wdata(prefix),
    .raddr(p_raddr),
    .rdata(p_rdata)
  );

  srp_search u_search (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl_q),
    .h     (sky_rdata),
    .p     (p_rdata),
    .prefix(prefix),
    .found (found),
    .best  (best),
    .best_x(best_x)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      placed <= res_placed;
      pos_x  <= 10'(res_x);
      pos_y  <= res_y;
    end
  end

`ifndef SYNTHESIS
  a_no_sky_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FWD || state == ST_BWD || state == ST_TURN) |-> !sky_we)
    else $error("skyline written during a search pass");

  a_no_pfx_write_in_bwd: assert property (@(posedge clk) disable iff (rst)
    p_we |-> state != ST_BWD)
    else $error("prefix write overlaps backward reads");

  a_span_in_bin: assert property (@(posedge clk) disable iff (rst)
    state == ST_WRITE |-> col < wide)
    else $error("span write beyond the effective width");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !placed |-> pos_x == '0 && pos_y == '0)
    else $error("failed placement with non-zero position");
`endif

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the skyline rectangle packer: directed and random placements.
`timescale 1ns / 1ps
module testbench
  import srp_pkg::*;
();

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 3 * MAX_BIN_WIDTH + 16;

  typedef struct {
    logic        placed;
    logic [9:0]  x;
    logic [10:0] y;
  } placement_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = REG_BIN_WIDTH;
  logic [10:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        operation = OP_CLEAR;
  logic [10:0] rect_width = '0;
  logic [10:0] rect_height = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        placed;
  logic [9:0]  pos_x;
  logic [10:0] pos_y;

  // Own copy of the block's state and registers
  logic [10:0] skyline [MAX_BIN_WIDTH] = '{default: '0};
  int          bin_cols = 1024;
  int          bin_rows = 1024;

  placement_t  expected_placements [$];
  int          mismatches = 0;
  int          send_idle_pct = 6;
  int          recv_stall_pct = 66;
  int          hold_requests = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  skyline_rect_packer dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .rect_width(rect_width),
    .rect_height(rect_height),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .placed(placed),
    .pos_x(pos_x),
    .pos_y(pos_y)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bottom-left skyline placement on the local copy of the skyline
  function automatic placement_t place_on_skyline(logic op, logic [10:0] rw_in,
                                                  logic [10:0] rh_in);
    placement_t res;
    int cols, rw, rh, lowest, lowest_x, span_top;
    res = '{placed: 1'b0, x: '0, y: '0};
    cols = (bin_cols > MAX_BIN_WIDTH) ? MAX_BIN_WIDTH : bin_cols;
    rw = rw_in;
    rh = rh_in;
    if (op == OP_CLEAR) begin
      foreach (skyline[i]) skyline[i] = '0;
      res.placed = 1'b1;
      return res;
    end
    if (rw > cols) return res;
    lowest = bin_rows;
    lowest_x = 0;
    for (int k = 0; k + rw <= cols; k++) begin
      span_top = 0;
      for (int j = k; j < k + rw && span_top < lowest; j++)
        if (skyline[j] > span_top) span_top = skyline[j];
      if (span_top < lowest) begin
        lowest = span_top;
        lowest_x = k;
      end
    end
    if (lowest + rh > bin_rows) return res;
    for (int j = lowest_x; j < lowest_x + rw && j < cols; j++)
      skyline[j] = 11'(lowest + rh);
    res.placed = 1'b1;
    res.x = lowest_x[9:0];
    res.y = lowest[10:0];
    return res;
  endfunction

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic compare_field(string name, logic [10:0] want, logic [10:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    placement_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_placements.size() == 0) begin
        $display("%0t: result with none expected, placed %0d x %0d y %0d",
                 $time, placed, pos_x, pos_y);
        mismatches++;
      end else begin
        want = expected_placements.pop_front();
        compare_field("placed", 11'(want.placed), 11'(placed));
        compare_field("pos_x", 11'(want.x), 11'(pos_x));
        compare_field("pos_y", want.y, pos_y);
      end
    end
  end

  // Watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(logic op, int w, int h);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    rect_width <= w[10:0];
    rect_height <= h[10:0];
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    expected_placements.push_back(place_on_skyline(op, w[10:0], h[10:0]));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_placements.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_bin(int cols, int rows);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_index <= REG_BIN_WIDTH;
    cfg_data <= cols[10:0];
    @(posedge clk);
    cfg_index <= REG_BIN_HEIGHT;
    cfg_data <= rows[10:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    bin_cols = cols;
    bin_rows = rows;
  endtask

  // Largest bin: zero width, whole-bin rectangle, nothing below the limit, last column
  task automatic test_full_bin();
    set_bin(1024, 1024);
    send_item(OP_PLACE, 0, 0);
    send_item(OP_PLACE, 1024, 1024);
    send_item(OP_PLACE, 1, 0);
    send_item(OP_PLACE, 1, 1);
    send_item(OP_PLACE, 0, 1024);
    send_item(OP_CLEAR, 1024, 1024);
    send_item(OP_PLACE, 1023, 7);
    send_item(OP_PLACE, 1, 3);
    send_item(OP_PLACE, 2, 1024);
    send_item(OP_PLACE, 512, 1017);
  endtask

  // One column, height one
  task automatic test_tiny_bin();
    set_bin(1, 1);
    send_item(OP_CLEAR, 0, 0);
    send_item(OP_PLACE, 2, 0);
    send_item(OP_PLACE, 1, 1);
    send_item(OP_PLACE, 1, 0);
    send_item(OP_PLACE, 0, 0);
    send_item(OP_PLACE, 0, 2);
    send_item(OP_PLACE, 1024, 1024);
  endtask

  // Columns beyond a narrowed bin keep their height; heights above a lowered limit
  task automatic test_shrunk_bin();
    set_bin(1024, 1024);
    send_item(OP_CLEAR, 0, 0);
    send_item(OP_PLACE, 1024, 600);
    set_bin(8, 100);
    send_item(OP_PLACE, 4, 0);
    send_item(OP_PLACE, 4, 0);
    send_item(OP_PLACE, 3, 1);
    set_bin(8, 1024);
    send_item(OP_PLACE, 4, 10);
    set_bin(1024, 1024);
    send_item(OP_PLACE, 8, 5);
  endtask

  task automatic test_random_packing(int idle_pct, int stall_pct, int segments, int items);
    int cols, rows, r, w, h;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (segments) begin
      r = $urandom_range(0, 99);
      cols = (r < 4) ? MAX_BIN_WIDTH : (r < 12) ? 1 : $urandom_range(2, 40);
      r = $urandom_range(0, 99);
      rows = (r < 10) ? 1024 : (r < 18) ? 1 : $urandom_range(4, 80);
      set_bin(cols, rows);
      repeat (items) begin
        r = $urandom_range(0, 99);
        if (r < 7) begin
          send_item(OP_CLEAR, $urandom_range(0, 1024), $urandom_range(0, 1024));
        end else if (r < 11) begin
          send_item($urandom_range(0, 1) ? OP_PLACE : OP_CLEAR,
                    $urandom_range(0, 1024), $urandom_range(0, 1024));
        end else begin
          r = $urandom_range(0, 19);
          if (r == 0)
            w = 0;
          else if (r == 1 && cols < MAX_BIN_WIDTH)
            w = $urandom_range(cols + 1, 1024);
          else
            w = $urandom_range(1, cols);
          h = $urandom_range(0, rows / 3 + 1);
          send_item(OP_PLACE, w, h);
        end
      end
    end
  endtask

  // Receiver holds off while the sender keeps offering; the block must stall its input
  task automatic test_backpressure();
    send_idle_pct = 0;
    set_bin(16, 64);
    hold_requests++;
    repeat (8) send_item(OP_PLACE, $urandom_range(1, 16), $urandom_range(0, 12));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_full_bin();
    test_tiny_bin();
    test_shrunk_bin();
    test_random_packing(6, 66, 4, 22);
    test_random_packing(66, 6, 4, 22);
    test_random_packing(0, 0, 4, 22);
    test_backpressure();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
